[hdl/bpfa_pkg.sv]
`default_nettype none
package bpfa_pkg;
  localparam int MAX_PAGES_DEF     = 65536;
  localparam int MAP_WORD_BITS_DEF = 64;
  localparam int TOTAL_W  = 17;
  localparam int PAGE_W   = 16;
  localparam int CMD_W    = 3;
  localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PAGE_W-1:0]  first_page;
    logic [TOTAL_W-1:0] page_count;
  } bpfa_in_t;

  typedef struct packed {
    logic               ok;
    logic [PAGE_W-1:0]  found_page;
    logic [TOTAL_W-1:0] free_pages;
    logic [TOTAL_W-1:0] used_pages;
    logic [TOTAL_W-1:0] reserved_pages;
  } bpfa_out_t;
endpackage
`default_nettype wire

[hdl/bpfa_if.sv]
`default_nettype none
interface bpfa_in_if import bpfa_pkg::*; ();
  logic     valid;
  logic     ready;
  bpfa_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpfa_out_if import bpfa_pkg::*; ();
  logic      valid;
  logic      ready;
  bpfa_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpfa_cfg_if import bpfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/bpfa_map_ram.sv]
`default_nettype none
// Busy map storage: one write port, one registered read port.
module bpfa_map_ram #(
  parameter int WORDS = 1024,
  parameter int WBITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [WBITS-1:0]         wdata,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output      logic [WBITS-1:0]         rdata
);
  logic [WBITS-1:0] mem [WORDS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/bitmap_page_frame_allocator.sv]
// Bitmap page frame allocator.
// Channels: in_ (cmd, first_page, page_count) and out_ (ok, found_page and the
// free/used/reserved counters), both valid/ready; cfg_ writes total_pages.
// One item is worked at a time. The search reads one map word at a time
// (S_SRD, S_SCHK); the run update reads a word, registers it and writes it back.
// Clearing pass after reset writes zero to all MAX_PAGES/MAP_WORD_BITS words
// (1024 by default); in_ready is low meanwhile; cfg writes are taken as ever.
// A zero-length request and an unknown command go straight to the result.
// The memory port reads or writes one word per access; its read is registered.
// The result sits in an output register; while out_ready is low it holds and
// no new item is taken. cfg writes reload free_pages from the effective total
// and must come only while the block is idle.
`default_nettype none
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_PAGES     = MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  bpfa_in_if.sink    in_ch,
  bpfa_out_if.source out_ch,
  bpfa_cfg_if.sink   cfg_ch
);
  localparam int WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(MAP_WORD_BITS);
  localparam int IW    = AW + BW + 2;  // page index, room past the end
  localparam int CW    = (IW > TOTAL_W) ? IW : TOTAL_W;
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SRD = 4'd2, S_SCHK = 4'd3,
    S_MRD = 4'd4, S_MWAIT = 4'd5, S_MWR = 4'd6, S_DONE = 4'd7;

  logic [3:0]         st_r, st_nxt;
  logic [AW:0]        wa_r;                 // word address, extra bit for end
  logic [TOTAL_W-1:0] total_r;
  logic [CW-1:0]      free_r, used_r, rsv_r;
  logic [CW-1:0]      run_r;                // running clear-bit run length
  logic [IW-1:0]      beg_r, end_r;         // run [beg, end)
  logic [CMD_W-1:0]   cmd_r;
  logic [TOTAL_W-1:0] cnt_r;
  logic               ok_r;
  logic [PAGE_W-1:0]  found_r;
  logic               ov_r;
  logic [MAP_WORD_BITS-1:0] word_r, rdata;
  logic               we;
  logic [MAP_WORD_BITS-1:0] wdata;

  // effective total
  logic [CW-1:0] tot;
  assign tot = (CW'(total_r) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(total_r);

  // clearing pass writes zero words
  bpfa_map_ram #(.WORDS(WORDS), .WBITS(MAP_WORD_BITS)) u_ram (
    .clk(clk), .we(we), .waddr(wa_r[AW-1:0]),
    .wdata((st_r == S_CLR) ? '0 : wdata),
    .raddr(wa_r[AW-1:0]), .rdata(rdata));

  // word base page index
  logic [IW-1:0] base;
  assign base = IW'(wa_r) << BW;

  // search within one word: the clear run ending at a bit is its distance to the
  // last busy bit below it, or with none the carried run plus its offset; the
  // lowest bit whose run reaches page_count ends the fit
  logic [CW-1:0] srun;
  logic          shit;
  logic [IW-1:0] sfound;
  always_comb begin
    logic [MAP_WORD_BITS-1:0] busy;
    logic [MAP_WORD_BITS-1:0] hitv;
    logic [BW-1:0]            lb;
    logic [BW-1:0]            hb;
    logic                     seen;
    logic [CW-1:0]            r;
    for (int b = 0; b < MAP_WORD_BITS; b++)
      busy[b] = rdata[b] || (CW'(base + IW'(b)) >= tot);
    lb = '0; seen = 1'b0; r = run_r; hitv = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (busy[b]) begin
        lb = BW'(b); seen = 1'b1; r = '0;
      end else if (seen) r = CW'(BW'(b) - lb);
      else r = run_r + CW'(b + 1);
      hitv[b] = !busy[b] && (r >= CW'(cnt_r));
    end
    srun = r;
    shit = |hitv;
    hb = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--)
      if (hitv[b]) hb = BW'(b);
    sfound = base + IW'(hb) + 1'b1 - IW'(cnt_r);
  end

  // modify one word over [beg,end): mask and changed-bit count
  logic          set_op;
  logic [MAP_WORD_BITS-1:0] mask, chg;
  logic [BW:0]   nchg;
  always_comb begin
    logic [IW-1:0] idx;
    set_op = (cmd_r == CMD_REQUEST) || (cmd_r == CMD_LOCK) || (cmd_r == CMD_RESERVE);
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      idx = base + IW'(b);
      mask[b] = (idx >= beg_r) && (idx < end_r);
    end
    chg   = set_op ? (mask & ~word_r) : (mask & word_r);
    wdata = set_op ? (word_r | mask) : (word_r & ~mask);
    nchg  = (BW+1)'($countones(chg));
  end

  // saturating counter moves by n pages
  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] c, logic [BW:0] n,
                                            logic [CW-1:0] lim);
    logic [CW:0] s;
    s = {1'b0, c} + (CW+1)'(n);
    return (s > {1'b0, lim}) ? ((c > lim) ? c : lim) : s[CW-1:0];
  endfunction
  function automatic logic [CW-1:0] sat_sub(logic [CW-1:0] c, logic [BW:0] n);
    return (c > CW'(n)) ? c - CW'(n) : '0;
  endfunction

  // end clamp for run commands
  logic [IW:0] rend;
  assign rend = (IW+1)'(in_ch.data.first_page) + (IW+1)'(in_ch.data.page_count);

  logic last_word;
  assign last_word = ((IW'(wa_r) + 1'b1) << BW) >= end_r;

  assign we = (st_r == S_MWR) || (st_r == S_CLR);
  assign in_ch.ready  = (st_r == S_IDLE) && !ov_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = '{ok: ok_r, found_page: found_r,
    free_pages: TOTAL_W'(free_r), used_pages: TOTAL_W'(used_r),
    reserved_pages: TOTAL_W'(rsv_r)};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:   if (wa_r == (AW+1)'(WORDS - 1)) st_nxt = S_IDLE;
      S_IDLE:  if (in_ch.valid && !ov_r) begin
        if (in_ch.data.cmd == CMD_REQUEST)
          st_nxt = (in_ch.data.page_count == '0) ? S_DONE : S_SRD;
        else if (in_ch.data.cmd > CMD_UNRESERVE) st_nxt = S_DONE;
        else st_nxt = S_MRD;
      end
      S_SRD:   st_nxt = S_SCHK;
      S_SCHK:  st_nxt = (shit) ? S_MRD :
                        ((base + IW'(MAP_WORD_BITS) >= IW'(tot)) ? S_DONE : S_SRD);
      S_MRD:   st_nxt = (IW'(base) >= end_r) ? S_DONE : S_MWAIT;
      S_MWAIT: st_nxt = S_MWR;
      S_MWR:   st_nxt = last_word ? S_DONE : S_MRD;
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; wa_r <= '0; ov_r <= 1'b0; total_r <= TOTAL_RESET;
      free_r <= CW'(MAX_PAGES < 65536 ? MAX_PAGES : 65536);
      used_r <= '0; rsv_r <= '0; ok_r <= 1'b0; found_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (cfg_ch.valid) begin
        total_r <= cfg_ch.data;
        free_r  <= (CW'(cfg_ch.data) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(cfg_ch.data);
      end
      case (st_r)
        S_CLR: wa_r <= wa_r + 1'b1;
        S_IDLE: if (in_ch.valid && !ov_r) begin
          cmd_r <= in_ch.data.cmd; cnt_r <= in_ch.data.page_count;
          ok_r <= 1'b1; found_r <= '0; run_r <= '0;
          beg_r <= IW'(in_ch.data.first_page);
          end_r <= (rend > (IW+1)'(tot)) ? IW'(tot) : IW'(rend);
          wa_r  <= (in_ch.data.cmd == CMD_REQUEST) ? '0
                   : (AW+1)'(in_ch.data.first_page >> BW);
          if (in_ch.data.cmd == CMD_REQUEST) ok_r <= 1'b0;
        end
        S_SCHK: begin
          run_r <= srun;
          if (shit) begin
            ok_r <= 1'b1; found_r <= PAGE_W'(sfound);
            beg_r <= sfound; end_r <= sfound + IW'(cnt_r);
            wa_r <= (AW+1)'(sfound >> BW);
          end else wa_r <= wa_r + 1'b1;
        end
        S_MWAIT: word_r <= rdata;
        S_MWR: begin
          wa_r <= wa_r + 1'b1;
          if (set_op) begin
            free_r <= sat_sub(free_r, nchg);
            if (cmd_r == CMD_RESERVE) rsv_r <= sat_add(rsv_r, nchg, tot);
            else used_r <= sat_add(used_r, nchg, tot);
          end else begin
            free_r <= sat_add(free_r, nchg, tot);
            if (cmd_r == CMD_UNRESERVE) rsv_r <= sat_sub(rsv_r, nchg);
            else used_r <= sat_sub(used_r, nchg);
          end
        end
        S_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/bpfa_checker.sv]
`default_nettype none
module bpfa_props import bpfa_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire bpfa_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.found_page == '0) else $error("found on fail");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule
bind bitmap_page_frame_allocator bpfa_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire

[sim/bpfa_checker.sv]
`default_nettype none
module bpfa_checker import bpfa_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  bpfa_in_if       in_ch,
  bpfa_out_if      out_ch,
  bpfa_cfg_if      cfg_ch,
  output int       fail_count,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the allocator state
  bit        page_busy [MAX_PAGES_DEF];
  int        total_reg;
  int        free_c;
  int        used_c;
  int        rsv_c;
  int        errs;
  bpfa_out_t awaited [$];

  assign fail_count = errs;

  initial begin
    errs = 0;
    outstanding = 0;
  end

  function automatic int eff_total();
    return (total_reg > MAX_PAGES_DEF) ? MAX_PAGES_DEF : total_reg;
  endfunction

  function automatic void clear_state();
    foreach (page_busy[i]) page_busy[i] = 1'b0;
    total_reg = int'(TOTAL_RESET);
    free_c    = eff_total();
    used_c    = 0;
    rsv_c     = 0;
  endfunction

  // one page flips only if its bit really changes; counters saturate
  function automatic void touch_page(int idx, bit set_it, bit to_rsv);
    int lim;
    lim = eff_total();
    if (idx >= lim || page_busy[idx] == set_it) return;
    page_busy[idx] = set_it;
    if (set_it) begin
      if (free_c > 0) free_c--;
      if (to_rsv) begin
        if (rsv_c < lim) rsv_c++;
      end else if (used_c < lim) begin
        used_c++;
      end
    end else begin
      if (free_c < lim) free_c++;
      if (to_rsv) begin
        if (rsv_c > 0) rsv_c--;
      end else if (used_c > 0) begin
        used_c--;
      end
    end
  endfunction

  function automatic void walk_run(int first, int count, bit set_it, bit to_rsv);
    int stop;
    stop = first + count;
    if (stop > eff_total()) stop = eff_total();
    for (int i = first; i < stop; i++) touch_page(i, set_it, to_rsv);
  endfunction

  // first-fit search plus run commands
  function automatic bpfa_out_t allocate(bpfa_in_t it);
    bpfa_out_t r;
    int        first;
    int        count;
    int        run_len;
    int        at;
    bit        hit;
    first   = int'(it.first_page);
    count   = int'(it.page_count);
    run_len = 0;
    at      = 0;
    hit     = 1'b0;
    r.ok    = 1'b1;
    case (it.cmd)
      CMD_REQUEST: begin
        if (count != 0) begin
          for (int i = 0; i < eff_total() && !hit; i++) begin
            if (page_busy[i]) begin
              run_len = 0;
            end else begin
              run_len++;
              if (run_len == count) begin
                at  = i + 1 - count;
                hit = 1'b1;
              end
            end
          end
        end
        r.ok = hit;
        if (hit) walk_run(at, count, 1'b1, 1'b0);
        else at = 0;
      end
      CMD_FREE:      walk_run(first, count, 1'b0, 1'b0);
      CMD_LOCK:      walk_run(first, count, 1'b1, 1'b0);
      CMD_RESERVE:   walk_run(first, count, 1'b1, 1'b1);
      CMD_UNRESERVE: walk_run(first, count, 1'b0, 1'b1);
      default: ;
    endcase
    r.found_page     = at[PAGE_W-1:0];
    r.free_pages     = free_c[TOTAL_W-1:0];
    r.used_pages     = used_c[TOTAL_W-1:0];
    r.reserved_pages = rsv_c[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  // sample all channels at the edge, in order cfg, input, result
  always @(posedge clk) begin
    bpfa_out_t want;
    bpfa_out_t got;
    if (!rst_n) begin
      clear_state();
      awaited.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        total_reg = int'(cfg_ch.data);
        free_c    = eff_total();
      end
      if (in_ch.valid && in_ch.ready) awaited.push_back(allocate(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (awaited.size() == 0) begin
          $error("result item with no pending command");
          errs++;
        end else begin
          want = awaited.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("found_page", want.found_page, got.found_page);
          check_field("free_pages", want.free_pages, got.free_pages);
          check_field("used_pages", want.used_pages, got.used_pages);
          check_field("reserved_pages", want.reserved_pages, got.reserved_pages);
        end
      end
    end
    outstanding <= awaited.size();
  end
endmodule
`default_nettype wire

[sim/tb_bitmap_page_frame_allocator.sv]
`default_nettype none
module tb_bitmap_page_frame_allocator import bpfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_ITEMS = 560;

  logic clk;
  logic rst_n;
  logic calm;
  int   cycles;
  int   fail_count;
  int   outstanding;
  int   cur_total;

  bpfa_in_if  in_ch ();
  bpfa_out_if out_ch ();
  bpfa_cfg_if cfg_ch ();

  bitmap_page_frame_allocator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  bpfa_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  // result backpressure, none while calm
  always @(posedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 13);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** bitmap_page_frame_allocator: FAILED **");
      $finish;
    end
  end
  initial cycles = 0;

  // valid stays high across back-to-back items; dropped only for a gap
  task automatic send_cmd(logic [CMD_W-1:0] cmd, int first, int count);
    bpfa_in_t it;
    it.cmd        = cmd;
    it.first_page = first[PAGE_W-1:0];
    it.page_count = count[TOTAL_W-1:0];
    while (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // register writes only once every result is back
  task automatic set_total(int value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value[TOTAL_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_total = value;
  endtask

  task automatic random_cmd();
    int pick;
    int lim;
    int first;
    int count;
    logic [CMD_W-1:0] cmd;
    lim  = (cur_total > MAX_PAGES_DEF) ? MAX_PAGES_DEF : cur_total;
    pick = $urandom_range(99);
    if (pick < 38)      cmd = CMD_REQUEST;
    else if (pick < 58) cmd = CMD_FREE;
    else if (pick < 72) cmd = CMD_LOCK;
    else if (pick < 84) cmd = CMD_RESERVE;
    else if (pick < 95) cmd = CMD_UNRESERVE;
    else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    pick = $urandom_range(99);
    if (pick < 70)      count = $urandom_range(8);
    else if (pick < 97) count = $urandom_range(140);
    else                count = $urandom_range(MAX_PAGES_DEF);
    if ($urandom_range(9) == 0) first = $urandom_range(16'hFFFF);
    else first = $urandom_range((lim + 4 > 16'hFFFF) ? 16'hFFFF : lim + 4);
    send_cmd(cmd, first, count);
  endtask

  // stimulus
  initial begin
    int totals [9] = '{65536, 1, 0, 131071, 200, 64, 65535, 1000, 65536};
    cur_total = int'(TOTAL_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners of each field and each command
    send_cmd(CMD_REQUEST, 0, 0);
    send_cmd(CMD_REQUEST, 16'hFFFF, 1);
    send_cmd(CMD_REQUEST, 0, 65536);
    send_cmd(CMD_REQUEST, 0, 65535);
    send_cmd(CMD_FREE, 0, 65536);
    send_cmd(CMD_LOCK, 65535, 65536);
    send_cmd(CMD_LOCK, 65535, 1);
    send_cmd(CMD_RESERVE, 10, 5);
    send_cmd(CMD_LOCK, 8, 10);
    send_cmd(CMD_FREE, 12, 2);
    send_cmd(CMD_UNRESERVE, 8, 10);
    send_cmd(CMD_REQUEST, 0, 3);
    send_cmd(CMD_REQUEST, 0, 70);
    send_cmd(CMD_SPARE_LO, 5, 5);
    send_cmd(CMD_SPARE_HI, 16'hFFFF, 65536);
    send_cmd(CMD_RESERVE, 0, 65536);
    send_cmd(CMD_UNRESERVE, 0, 65536);
    set_total(3);
    send_cmd(CMD_REQUEST, 0, 4);
    send_cmd(CMD_REQUEST, 0, 3);
    send_cmd(CMD_FREE, 0, 65536);
    send_cmd(CMD_LOCK, 2, 5);

    // random phases across register settings
    for (int p = 0; p < 9; p++) begin
      set_total(totals[p]);
      calm = (p == 4);
      for (int n = 0; n < RANDOM_ITEMS / 9; n++) random_cmd();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** bitmap_page_frame_allocator: PASSED **");
    end else begin
      $display("** bitmap_page_frame_allocator: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/bpfa_pkg.sv
hdl/bpfa_if.sv
hdl/bpfa_map_ram.sv
hdl/bitmap_page_frame_allocator.sv
hdl/bpfa_checker.sv
sim/bpfa_checker.sv
sim/tb_bitmap_page_frame_allocator.sv
